// File: src/mexp_pkg.sv
package mexp_pkg;

	// Sequencer states of the top level, one-hot.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_CHECK  = 5'b00100,
		S_MULT   = 5'b01000,
		S_FINISH = 5'b10000
	} mexp_state_t;

	// Status that a modular multiplier reports to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mul_sts_t;

endpackage

// File: src/mexp_modmul.sv
// Bit-serial modular multiplier: product = (x * y) mod m by double-and-add.
// Each multiplier bit of y is consumed in a doubling step followed by
// a conditional add step, so one modular adder is shared by both steps.
// The operand x must be below m. The operand y may take any value.
module mexp_modmul #(
	parameter int WORD_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [WORD_BITS-1:0]     x,
	input  logic [WORD_BITS-1:0]     y,
	input  logic [WORD_BITS-1:0]     m,
	output logic [WORD_BITS-1:0]     product,
	output mexp_pkg::mexp_mul_sts_t  sts
);

	localparam int CNT_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 phase_q;
	logic                 busy_q;
	logic                 done_q;

	logic [WORD_BITS-1:0] opnd;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS:0]   diff;
	logic [WORD_BITS-1:0] acc_d;
	logic                 add_en;

	// Phase zero doubles the accumulator, phase one adds x when the current
	// multiplier bit is set. Both are an add followed by one conditional
	// subtraction of the modulus.
	always_comb begin
		opnd   = phase_q ? x_q : acc_q;
		sum    = {1'b0, acc_q} + {1'b0, opnd};
		diff   = sum - {1'b0, m};
		acc_d  = (sum >= {1'b0, m}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
		add_en = !phase_q || y_q[WORD_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(WORD_BITS - 1);
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			if (add_en) begin
				acc_q <= acc_d;
			end
			if (phase_q) begin
				y_q <= y_q << 1;
			end
		end
	end

	assign product  = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");

	a_done_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> acc_q < m)
		else $error("multiplier result not reduced");

endmodule

// File: src/modular_exponentiation.sv
// Modular exponentiation: power = base ** exponent mod modulus, computed by
// right-to-left square-and-multiply with bit-serial modular multipliers.
// Input channel: in_valid / in_stall with base and exponent; a request is
// taken when in_valid is high and in_stall is low. in_stall is low only while
// the block is idle, so one request is worked on at a time.
// Output channel: out_valid / out_stall with power, held in an output register
// that waits as long as the receiver stalls; the next request may be taken
// while that result still waits.
// The modulus register is written with cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, and the block does not enforce this.
// Values 0 and 1 act as 2. Reset sets it to 2 and empties the block.
// After a request is taken, multiplier A first reduces the base by the
// modulus; each exponent bit up to the highest set one then costs one pass
// of the two multipliers (square and multiply run side by side), each pass
// taking a doubling step and an add step per bit of the word because one
// modular adder per multiplier does both double and add. A zero exponent
// needs no pass. The next request can be taken in the cycle after the
// result is loaded. While the output register is full and stalled, the
// block holds its result and keeps in_stall.
module modular_exponentiation #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [WORD_BITS-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] base,
	input  logic [WORD_BITS-1:0] exponent,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] power
);

	mexp_pkg::mexp_state_t   state_q;
	mexp_pkg::mexp_mul_sts_t sts_a;
	mexp_pkg::mexp_mul_sts_t sts_b;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] m_eff;
	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] power_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 start_a;
	logic                 start_b;
	logic [WORD_BITS-1:0] x_a;
	logic [WORD_BITS-1:0] y_a;
	logic [WORD_BITS-1:0] prod_a;
	logic [WORD_BITS-1:0] prod_b;
	logic                 out_free;

	// The user must change the modulus only while idle; the block does not enforce this, and the multipliers read it live.
	assign m_eff = (modulus_q < WORD_BITS'(2)) ? WORD_BITS'(2) : modulus_q;

	assign in_stall = (state_q != mexp_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Multiplier A first reduces the base (1 * base mod m), then forms the
	// running result times the base power. Multiplier B squares the base power.
	assign start_b = (state_q == mexp_pkg::S_CHECK) && (e_q != '0);
	assign start_a = accept || start_b;
	assign x_a     = (state_q == mexp_pkg::S_IDLE) ? WORD_BITS'(1) : r_q;
	assign y_a     = (state_q == mexp_pkg::S_IDLE) ? base : b_q;

	mexp_modmul #(.WORD_BITS(WORD_BITS)) u_mul_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a),
		.x       (x_a),
		.y       (y_a),
		.m       (m_eff),
		.product (prod_a),
		.sts     (sts_a)
	);

	mexp_modmul #(.WORD_BITS(WORD_BITS)) u_mul_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_b),
		.x       (b_q),
		.y       (b_q),
		.m       (m_eff),
		.product (prod_b),
		.sts     (sts_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_BITS'(2);
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	// Sequencer and output register valid. A new result may be loaded in the
	// same cycle as the waiting one is taken, and then valid stays high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == mexp_pkg::S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mexp_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= mexp_pkg::S_REDUCE;
					end
				end
				mexp_pkg::S_REDUCE: begin
					if (sts_a.done) begin
						state_q <= mexp_pkg::S_CHECK;
					end
				end
				mexp_pkg::S_CHECK: begin
					// Once the remaining exponent is zero the result is final.
					state_q <= (e_q != '0) ? mexp_pkg::S_MULT : mexp_pkg::S_FINISH;
				end
				mexp_pkg::S_MULT: begin
					if (sts_a.done) begin
						state_q <= mexp_pkg::S_CHECK;
					end
				end
				mexp_pkg::S_FINISH: begin
					if (out_free) begin
						state_q <= mexp_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mexp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Working values of the exponentiation.
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= exponent;
			r_q <= WORD_BITS'(1);
		end
		if ((state_q == mexp_pkg::S_REDUCE) && sts_a.done) begin
			b_q <= prod_a;
		end
		if ((state_q == mexp_pkg::S_MULT) && sts_a.done) begin
			if (e_q[0]) begin
				r_q <= prod_a;
			end
			b_q <= prod_b;
			e_q <= e_q >> 1;
		end
		if ((state_q == mexp_pkg::S_FINISH) && out_free) begin
			power_q <= r_q;
		end
	end

	assign out_valid = out_valid_q;
	assign power     = power_q;

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::S_MULT) |->
			(sts_a.busy == sts_b.busy) && (sts_a.done == sts_b.done))
		else $error("square and multiply passes out of step");

	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::S_CHECK) |-> (b_q < m_eff) && (r_q < m_eff))
		else $error("working values not below the modulus");

	a_exponent_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::S_MULT && sts_a.done) |=> e_q < $past(e_q))
		else $error("exponent did not advance");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> power_q < m_eff)
		else $error("result not below the modulus");

endmodule
